/* hdl/aik_pkg.sv */
`timescale 1ns / 1ps
package aik_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int TABLE_LEN = 24;
  localparam int NORM_CELLS = 6;
  localparam int SQRT_CELLS = 28;
  localparam int ATAN_STG = ANGLE_ITERATIONS + NORM_CELLS + 3;
  localparam int ST_SQ0 = 5;
  localparam int ST_MID = ST_SQ0 + SQRT_CELLS;
  localparam int ST_AT = ST_MID + 4;
  localparam int NSTG = ST_AT + ATAN_STG;

  localparam logic [1:0] CFG_BASE_HEIGHT = 2'd0;
  localparam logic [1:0] CFG_UPPER_LINK = 2'd1;
  localparam logic [1:0] CFG_LOWER_LINK = 2'd2;

  localparam logic [13:0] HALF_TURN64 = 14'd11520;
  localparam logic [14:0] TURN64 = 15'd23040;

  // atan(2^-i) in 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0: v = 30'h20000000;
      5'd1: v = 30'h12E4051E;
      5'd2: v = 30'h09FB385B;
      5'd3: v = 30'h051111D4;
      5'd4: v = 30'h028B0D43;
      5'd5: v = 30'h0145D7E1;
      5'd6: v = 30'h00A2F61E;
      5'd7: v = 30'h00517C55;
      5'd8: v = 30'h0028BE53;
      5'd9: v = 30'h00145F2F;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2F9;
      5'd15: v = 30'h0000517C;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A2F;
      5'd19: v = 30'h00000517;
      5'd20: v = 30'h0000028B;
      5'd21: v = 30'h00000145;
      5'd22: v = 30'h000000A2;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic su;
    logic sv;
    logic zr;
  } quad_t;

  typedef struct packed {
    logic signed [28:0] n;
    logic signed [15:0] h;
    logic [27:0] d;
    logic flag;
    logic signed [13:0] x;
    logic signed [13:0] y;
  } side_t;

endpackage

/* hdl/aik_stream_if.sv */
`timescale 1ns / 1ps
interface aik_in_if;
  logic valid;
  logic ready;
  logic signed [13:0] target_x;
  logic signed [13:0] target_y;
  logic signed [13:0] target_z;
  modport source(output valid, target_x, target_y, target_z, input ready);
  modport sink(input valid, target_x, target_y, target_z, output ready);
endinterface

interface aik_out_if;
  logic valid;
  logic ready;
  logic signed [14:0] base_angle;
  logic signed [14:0] shoulder_angle;
  logic [13:0] elbow_angle;
  logic out_of_reach;
  modport source(output valid, base_angle, shoulder_angle, elbow_angle, out_of_reach,
                 input ready);
  modport sink(input valid, base_angle, shoulder_angle, elbow_angle, out_of_reach,
               output ready);
endinterface

/* hdl/aik_sqrt_cell.sv */
`timescale 1ns / 1ps
module aik_sqrt_cell import aik_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [55:0] rad_i,
  input  logic [29:0] rem_i,
  input  logic [27:0] root_i,
  output logic [55:0] rad_o,
  output logic [29:0] rem_o,
  output logic [27:0] root_o
);
  logic [31:0] rem_sh, trial, rem_df;
  logic ge;

  // one root bit per cell
  assign rem_sh = {rem_i, rad_i[55:54]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge = rem_sh >= trial;
  assign rem_df = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o <= {rad_i[53:0], 2'b00};
      rem_o <= ge ? rem_df[29:0] : rem_sh[29:0];
      root_o <= {root_i[26:0], ge};
    end
  end
endmodule

/* hdl/aik_norm_cell.sv */
`timescale 1ns / 1ps
module aik_norm_cell import aik_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [5:0]  amt,
  input  logic [63:0] au_i,
  input  logic [63:0] av_i,
  output logic [63:0] au_o,
  output logic [63:0] av_o
);
  logic [63:0] hi_mask;
  logic fits;

  assign hi_mask = ~({64{1'b1}} >> amt);
  assign fits = ((au_i | av_i) & hi_mask) == 64'd0;

  always_ff @(posedge clk) begin
    if (en) begin
      au_o <= fits ? (au_i << amt) : au_i;
      av_o <= fits ? (av_i << amt) : av_i;
    end
  end
endmodule

/* hdl/aik_cordic_cell.sv */
`timescale 1ns / 1ps
module aik_cordic_cell import aik_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [4:0]         idx,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] y_i,
  input  logic signed [32:0] z_i,
  output logic signed [32:0] x_o,
  output logic signed [32:0] y_o,
  output logic signed [32:0] z_o
);
  logic signed [32:0] dx, dy, at;

  assign dx = y_i >>> idx;
  assign dy = x_i >>> idx;
  assign at = $signed({3'b000, atan_turn(idx)});

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[32]) begin
        x_o <= x_i + dx;
        y_o <= y_i - dy;
        z_o <= z_i + at;
      end else begin
        x_o <= x_i - dx;
        y_o <= y_i + dy;
        z_o <= z_i - at;
      end
    end
  end
endmodule

/* hdl/aik_atan2.sv */
`timescale 1ns / 1ps
module aik_atan2 import aik_pkg::*; (
  input  logic                clk,
  input  logic [ATAN_STG-1:0] en,
  input  logic signed [63:0]  v,
  input  logic signed [63:0]  u,
  output logic signed [14:0]  ang
);
  quad_t q_r [ATAN_STG-1];
  logic [63:0] au_r, av_r;
  logic [63:0] nau [NORM_CELLS];
  logic [63:0] nav [NORM_CELLS];
  logic signed [32:0] cx [ANGLE_ITERATIONS];
  logic signed [32:0] cy [ANGLE_ITERATIONS];
  logic signed [32:0] cz [ANGLE_ITERATIONS];
  logic signed [32:0] zf;
  logic [30:0] zc;
  logic [45:0] prod;
  logic [13:0] t_r;
  logic [13:0] tm;
  logic signed [14:0] ts;

  // magnitudes and quadrant
  always_ff @(posedge clk) begin
    if (en[0]) begin
      au_r <= u[63] ? 64'(-u) : 64'(u);
      av_r <= v[63] ? 64'(-v) : 64'(v);
      q_r[0] <= '{su: u[63], sv: v[63], zr: (u == 64'sd0) && (v == 64'sd0)};
    end
  end

  genvar k;
  generate
    for (k = 1; k < ATAN_STG - 1; k++) begin : g_q
      always_ff @(posedge clk) begin
        if (en[k]) q_r[k] <= q_r[k-1];
      end
    end

    // leading-one alignment to bit 63
    for (k = 0; k < NORM_CELLS; k++) begin : g_norm
      if (k == 0) begin : g_first
        aik_norm_cell u_cell (.clk(clk), .en(en[1]), .amt(6'(32 >> k)),
          .au_i(au_r), .av_i(av_r), .au_o(nau[k]), .av_o(nav[k]));
      end else begin : g_next
        aik_norm_cell u_cell (.clk(clk), .en(en[1+k]), .amt(6'(32 >> k)),
          .au_i(nau[k-1]), .av_i(nav[k-1]), .au_o(nau[k]), .av_o(nav[k]));
      end
    end

    for (k = 0; k < ANGLE_ITERATIONS; k++) begin : g_cordic
      if (k == 0) begin : g_first
        aik_cordic_cell u_cell (.clk(clk), .en(en[1+NORM_CELLS]), .idx(5'(k)),
          .x_i($signed({3'b000, nau[NORM_CELLS-1][63:34]})),
          .y_i($signed({3'b000, nav[NORM_CELLS-1][63:34]})),
          .z_i(33'sd0), .x_o(cx[k]), .y_o(cy[k]), .z_o(cz[k]));
      end else begin : g_next
        aik_cordic_cell u_cell (.clk(clk), .en(en[1+NORM_CELLS+k]), .idx(5'(k)),
          .x_i(cx[k-1]), .y_i(cy[k-1]), .z_i(cz[k-1]),
          .x_o(cx[k]), .y_o(cy[k]), .z_o(cz[k]));
      end
    end
  endgenerate

  // quadrant saturate, scale to 1/64 degree
  assign zf = cz[ANGLE_ITERATIONS-1];
  always_comb begin
    if (zf[32]) zc = 31'd0;
    else if (zf > 33'sh40000000) zc = 31'h40000000;
    else zc = zf[30:0];
  end
  assign prod = 46'(zc) * 46'(TURN64) + 46'h80000000;

  always_ff @(posedge clk) begin
    if (en[ATAN_STG-2]) t_r <= prod[45:32];
  end

  assign tm = q_r[ATAN_STG-2].su ? (HALF_TURN64 - t_r) : t_r;
  assign ts = q_r[ATAN_STG-2].sv ? -$signed({1'b0, tm}) : $signed({1'b0, tm});

  always_ff @(posedge clk) begin
    if (en[ATAN_STG-1]) ang <= q_r[ATAN_STG-2].zr ? 15'sd0 : ts;
  end
endmodule

/* hdl/arm_inverse_kinematics_3dof.sv */
`timescale 1ns / 1ps
// Three-joint arm inverse kinematics: target (x, y, z) in 1/16 mm in,
// base / shoulder / elbow angles in 1/64 degree and a reach flag out.
// in_ch: valid/ready request channel carrying target_x/y/z.
// out_ch: valid/ready request channel carrying the joint angles and
//   out_of_reach (elbow cosine clamped to [-1, 1]).
// cfg_*: single-cycle write port, index 0 base_height, 1 upper_link,
//   2 lower_link; write only while nothing is in flight.
// Throughput: one request per cycle unless a stalled out_ch has every stage
//   full. Pipeline: 5 capture/multiply/clamp stages, 28 square-root cells
//   (one root bit each), 4 shoulder-operand stages, then the atan2 chains (abs, 6
//   normalize cells, one cell per CORDIC step, scale, quadrant fix).
// Every stage has its own valid bit; a stage loads whenever it is empty or
//   the stage ahead loads, so a stalled receiver only holds the full stages
//   and in_ch.ready stays high while any bubble remains.
// Reset (synchronous, rst_n low) empties the pipeline and restores the
//   default link lengths.
module arm_inverse_kinematics_3dof import aik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  aik_in_if.sink      in_ch,
  aik_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [12:0] cfg_wdata
);
  logic [12:0] base_height_r, upper_link_r, lower_link_r;
  logic [NSTG-1:0] vld_r, en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r <= 13'd2483;
      upper_link_r <= 13'd2240;
      lower_link_r <= 13'd3040;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE_HEIGHT: base_height_r <= cfg_wdata;
        CFG_UPPER_LINK: upper_link_r <= cfg_wdata;
        CFG_LOWER_LINK: lower_link_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage loads if out_ch is ready or any stage at or ahead of it has room
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_en
      assign en[g] = out_ch.ready | ~(&vld_r[NSTG-1:g]);
      always_ff @(posedge clk) begin
        if (!rst_n) vld_r[g] <= 1'b0;
        else if (en[g]) vld_r[g] <= (g == 0) ? in_ch.valid : vld_r[(g == 0) ? 0 : g-1];
      end
    end
  endgenerate

  assign in_ch.ready = en[0];
  assign out_ch.valid = vld_r[NSTG-1];

  // stage 0: capture
  logic signed [13:0] x0_r, y0_r, z0_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0_r <= in_ch.target_x;
      y0_r <= in_ch.target_y;
      z0_r <= in_ch.target_z;
    end
  end

  // stage 1: squares, height offset, 2ab
  logic signed [27:0] xsq, ysq;
  logic signed [15:0] h_nxt;
  logic signed [29:0] hh_nxt;
  logic [25:0] ab_nxt;
  logic [27:0] rr1_r, d1_r;
  logic [28:0] hh1_r;
  logic [25:0] aa1_r, bb1_r;
  logic signed [15:0] h1_r;
  logic signed [13:0] x1_r, y1_r;
  assign xsq = x0_r * x0_r;
  assign ysq = y0_r * y0_r;
  assign h_nxt = $signed({3'b000, base_height_r}) - 16'(z0_r);
  assign hh_nxt = h_nxt * h_nxt;
  assign ab_nxt = upper_link_r * lower_link_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rr1_r <= 28'(xsq) + 28'(ysq);
      hh1_r <= hh_nxt[28:0];
      aa1_r <= upper_link_r * upper_link_r;
      bb1_r <= lower_link_r * lower_link_r;
      d1_r <= {1'b0, ab_nxt, 1'b0};
      h1_r <= h_nxt;
      x1_r <= x0_r;
      y1_r <= y0_r;
    end
  end

  // stage 2: cosine numerator and clamp
  logic signed [30:0] n_raw, d_s;
  logic [30:0] n_sum;
  logic signed [28:0] n2_r;
  logic [27:0] rr2_r, d2_r;
  logic flag2_r;
  logic signed [15:0] h2_r;
  logic signed [13:0] x2_r, y2_r;
  assign n_sum = 31'(rr1_r) + 31'(hh1_r) - 31'(aa1_r) - 31'(bb1_r);
  assign n_raw = $signed(n_sum);
  assign d_s = $signed({3'b000, d1_r});
  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (n_raw > d_s) begin
        n2_r <= 29'(d_s);
        flag2_r <= 1'b1;
      end else if (n_raw < -d_s) begin
        n2_r <= 29'(-d_s);
        flag2_r <= 1'b1;
      end else begin
        n2_r <= n_raw[28:0];
        flag2_r <= 1'b0;
      end
      rr2_r <= rr1_r;
      d2_r <= d1_r;
      h2_r <= h1_r;
      x2_r <= x1_r;
      y2_r <= y1_r;
    end
  end

  // stage 3: d^2, n^2
  logic signed [55:0] nn_nxt;
  logic [54:0] dd3_r, nn3_r;
  logic [27:0] rr3_r;
  side_t side3_r, side4_r;
  assign nn_nxt = n2_r * n2_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      dd3_r <= d2_r * d2_r;
      nn3_r <= nn_nxt[54:0];
      rr3_r <= rr2_r;
      side3_r <= '{n: n2_r, h: h2_r, d: d2_r, flag: flag2_r, x: x2_r, y: y2_r};
    end
  end

  // stage 4: sine radicand
  logic [54:0] df4_r;
  logic [27:0] rr4_r;
  always_ff @(posedge clk) begin
    if (en[4]) begin
      df4_r <= dd3_r - nn3_r;
      rr4_r <= rr3_r;
      side4_r <= side3_r;
    end
  end

  // square-root chains: reach r and sine s, side by side
  logic [55:0] rad_s [SQRT_CELLS];
  logic [29:0] rem_s [SQRT_CELLS];
  logic [27:0] root_s [SQRT_CELLS];
  logic [55:0] rad_r [SQRT_CELLS];
  logic [29:0] rem_r [SQRT_CELLS];
  logic [27:0] root_r [SQRT_CELLS];
  side_t side_q [SQRT_CELLS];
  generate
    for (g = 0; g < SQRT_CELLS; g++) begin : g_sqrt
      if (g == 0) begin : g_first
        aik_sqrt_cell u_s (.clk(clk), .en(en[ST_SQ0]), .rad_i({1'b0, df4_r}),
          .rem_i(30'd0), .root_i(28'd0),
          .rad_o(rad_s[g]), .rem_o(rem_s[g]), .root_o(root_s[g]));
        aik_sqrt_cell u_r (.clk(clk), .en(en[ST_SQ0]), .rad_i({28'd0, rr4_r}),
          .rem_i(30'd0), .root_i(28'd0),
          .rad_o(rad_r[g]), .rem_o(rem_r[g]), .root_o(root_r[g]));
        always_ff @(posedge clk) begin
          if (en[ST_SQ0]) side_q[g] <= side4_r;
        end
      end else begin : g_next
        aik_sqrt_cell u_s (.clk(clk), .en(en[ST_SQ0+g]), .rad_i(rad_s[g-1]),
          .rem_i(rem_s[g-1]), .root_i(root_s[g-1]),
          .rad_o(rad_s[g]), .rem_o(rem_s[g]), .root_o(root_s[g]));
        aik_sqrt_cell u_r (.clk(clk), .en(en[ST_SQ0+g]), .rad_i(rad_r[g-1]),
          .rem_i(rem_r[g-1]), .root_i(root_r[g-1]),
          .rad_o(rad_r[g]), .rem_o(rem_r[g]), .root_o(root_r[g]));
        always_ff @(posedge clk) begin
          if (en[ST_SQ0+g]) side_q[g] <= side_q[g-1];
        end
      end
    end
  endgenerate

  side_t sq;
  logic [27:0] s_w;
  logic [13:0] r_w;
  assign sq = side_q[SQRT_CELLS-1];
  assign s_w = root_s[SQRT_CELLS-1];
  assign r_w = root_r[SQRT_CELLS-1][13:0];

  // shoulder operands: P = b*n + a*d, Q = b*s
  logic signed [42:0] bn_nxt;
  logic signed [42:0] bn_r, p_r;
  logic [40:0] ad_r, q_r, q2_r;
  logic [13:0] r_r, r2_r;
  logic [27:0] s_r, s2_r, s3_r, s4_r;
  side_t m1_r, m2_r, m3_r, m4_r;
  assign bn_nxt = $signed({1'b0, lower_link_r}) * sq.n;
  always_ff @(posedge clk) begin
    if (en[ST_MID]) begin
      bn_r <= bn_nxt;
      ad_r <= upper_link_r * sq.d;
      q_r <= lower_link_r * s_w;
      r_r <= r_w;
      s_r <= s_w;
      m1_r <= sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_MID+1]) begin
      p_r <= bn_r + $signed({2'b00, ad_r});
      q2_r <= q_r;
      r2_r <= r_r;
      s2_r <= s_r;
      m2_r <= m1_r;
    end
  end

  logic signed [57:0] hp_nxt, rq_nxt, hq_nxt, rp_nxt;
  logic signed [57:0] hp_r, rq_r, hq_r, rp_r;
  assign hp_nxt = m2_r.h * p_r;
  assign rq_nxt = $signed({1'b0, r2_r}) * $signed({1'b0, q2_r});
  assign hq_nxt = m2_r.h * $signed({1'b0, q2_r});
  assign rp_nxt = $signed({1'b0, r2_r}) * p_r;
  always_ff @(posedge clk) begin
    if (en[ST_MID+2]) begin
      hp_r <= hp_nxt;
      rq_r <= rq_nxt;
      hq_r <= hq_nxt;
      rp_r <= rp_nxt;
      s3_r <= s2_r;
      m3_r <= m2_r;
    end
  end

  logic signed [63:0] v_r, u_r;
  logic signed [63:0] hp64, rq64, hq64, rp64;
  assign hp64 = hp_r;
  assign rq64 = rq_r;
  assign hq64 = hq_r;
  assign rp64 = rp_r;
  always_ff @(posedge clk) begin
    if (en[ST_MID+3]) begin
      v_r <= hp64 - rq64;
      u_r <= hq64 + rp64;
      s4_r <= s3_r;
      m4_r <= m3_r;
    end
  end

  // three angle chains in lockstep
  logic signed [63:0] bv, bu, ev, eu;
  logic signed [14:0] base_ang, elb_ang, sh_ang;
  assign bv = m4_r.y;
  assign bu = m4_r.x;
  assign ev = $signed({36'd0, s4_r});
  assign eu = m4_r.n;

  aik_atan2 u_base (.clk(clk), .en(en[NSTG-1:ST_AT]), .v(bv), .u(bu), .ang(base_ang));
  aik_atan2 u_elbow (.clk(clk), .en(en[NSTG-1:ST_AT]), .v(ev), .u(eu), .ang(elb_ang));
  aik_atan2 u_shoulder (.clk(clk), .en(en[NSTG-1:ST_AT]), .v(v_r), .u(u_r),
    .ang(sh_ang));

  logic flag_r [ATAN_STG];
  generate
    for (g = 0; g < ATAN_STG; g++) begin : g_flag
      always_ff @(posedge clk) begin
        if (en[ST_AT+g]) flag_r[g] <= (g == 0) ? m4_r.flag : flag_r[(g == 0) ? 0 : g-1];
      end
    end
  endgenerate

  assign out_ch.base_angle = base_ang;
  assign out_ch.shoulder_angle = sh_ang;
  assign out_ch.elbow_angle = elb_ang[13:0];
  assign out_ch.out_of_reach = flag_r[ATAN_STG-1];

  // input is refused only with every stage occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r)) else $error("ready low with a free stage");

  // an accepted request lands in stage 0
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[0]) else $error("accepted request lost");

  // elbow stays within a half turn
  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.elbow_angle <= HALF_TURN64)) else $error("elbow out of range");

  // a full final stage that is not taken keeps its valid
  a_hold_tail: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTG-1] && !out_ch.ready |=> vld_r[NSTG-1]) else $error("result dropped");
endmodule

/* dv/ik_checker.sv */
`timescale 1ns / 1ps
module ik_checker import aik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  aik_in_if.sink      in_mon,
  aik_out_if.sink     out_mon,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [12:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          angles_seen,
  output int          reach_flags
);

  typedef struct {
    logic signed [14:0] base;
    logic signed [14:0] shoulder;
    logic [13:0] elbow;
    logic reach;
  } joints_t;

  joints_t joint_q[$];
  longint link_a, link_b, shoulder_h;

  function automatic longint root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] atan_step(int i);
    logic [31:0] tbl [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
    return tbl[i];
  endfunction

  function automatic longint cordic_angle(longint v, longint u);
    longint unsigned au, av;
    longint xv, yv, zv, dx, dy, t;
    au = u < 0 ? -u : u;
    av = v < 0 ? -v : v;
    zv = 0;
    if (au == 0 && av == 0) return 0;
    while ((au | av) >= (64'd1 << 30)) begin
      au >>= 1;
      av >>= 1;
    end
    while ((au | av) < (64'd1 << 29)) begin
      au <<= 1;
      av <<= 1;
    end
    xv = au;
    yv = av;
    for (int i = 0; i < ANGLE_ITERATIONS && i < TABLE_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        zv += longint'(atan_step(i));
      end else begin
        xv -= dx;
        yv += dy;
        zv -= longint'(atan_step(i));
      end
    end
    if (zv < 0) zv = 0;
    if (zv > (64'sd1 <<< 30)) zv = 64'sd1 <<< 30;
    t = (zv * 23040 + (64'sd1 <<< 31)) >>> 32;
    if (u < 0) t = 11520 - t;
    if (v < 0) t = -t;
    return t;
  endfunction

  function automatic joints_t solve_joints(longint x, longint y, longint z);
    joints_t j;
    longint h, rr, r, d, n, s, p, q;
    h = shoulder_h - z;
    rr = x * x + y * y;
    r = root64(rr);
    d = 2 * link_a * link_b;
    n = rr + h * h - link_a * link_a - link_b * link_b;
    j.reach = 1'b0;
    if (n > d) begin
      n = d;
      j.reach = 1'b1;
    end else if (n < -d) begin
      n = -d;
      j.reach = 1'b1;
    end
    s = root64(d * d - n * n);
    p = link_b * n + link_a * d;
    q = link_b * s;
    j.base = 15'(cordic_angle(y, x));
    j.elbow = 14'(cordic_angle(s, n));
    j.shoulder = 15'(cordic_angle(h * p - r * q, h * q + r * p));
    return j;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  assign pending = joint_q.size();

  always @(posedge clk) begin
    joints_t w;
    if (!rst_n) begin
      link_a <= 2240;
      link_b <= 3040;
      shoulder_h <= 2483;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BASE_HEIGHT: shoulder_h <= cfg_wdata;
          CFG_UPPER_LINK: link_a <= cfg_wdata;
          CFG_LOWER_LINK: link_b <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        joint_q.push_back(solve_joints(in_mon.target_x, in_mon.target_y,
                                       in_mon.target_z));
      if (out_mon.valid && out_mon.ready) begin
        angles_seen++;
        if (out_mon.out_of_reach) reach_flags++;
        if (joint_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          w = joint_q.pop_front();
          if (out_mon.base_angle !== w.base)
            report_mismatch("base_angle", out_mon.base_angle, w.base);
          if (out_mon.shoulder_angle !== w.shoulder)
            report_mismatch("shoulder_angle", out_mon.shoulder_angle, w.shoulder);
          if (out_mon.elbow_angle !== w.elbow)
            report_mismatch("elbow_angle", out_mon.elbow_angle, w.elbow);
          if (out_mon.out_of_reach !== w.reach)
            report_mismatch("out_of_reach", out_mon.out_of_reach, w.reach);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    angles_seen = 0;
    reach_flags = 0;
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Stream test of the three-joint inverse kinematics pipeline.
// Stimulus: directed corner targets, then random targets biased toward the
// reachable shell, across several link settings including the extremes.
// The checker predicts each request's joint angles and compares in order.
module tb;
  import aik_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [12:0] cfg_wdata;
  int          fails, pending, seen, flagged;
  int          send_idle, recv_idle;  // idle percentage per side

  aik_in_if  in_ch();
  aik_out_if out_ch();

  arm_inverse_kinematics_3dof dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata));

  ik_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fails), .pending(pending), .angles_seen(seen),
    .reach_flags(flagged));

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // receiver: random stalls per current idle rate
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // one target request; optional leading idle cycles, then hold until taken
  task automatic send_target(logic signed [13:0] x, logic signed [13:0] y,
                             logic signed [13:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.target_x <= x;
    in_ch.target_y <= y;
    in_ch.target_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drain, then let the pipeline empty before touching the registers
  task automatic write_links(logic [12:0] hgt, logic [12:0] a, logic [12:0] b);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_BASE_HEIGHT;
    cfg_wdata <= hgt;
    @(posedge clk);
    cfg_idx <= CFG_UPPER_LINK;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_idx <= CFG_LOWER_LINK;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random target: mostly near the reach shell of the current links
  task automatic random_target(int a, int b, int hgt);
    int rad, ang, zz;
    logic signed [13:0] x, y, z;
    if ($urandom_range(3) == 0) begin
      x = 14'($urandom);
      y = 14'($urandom);
      z = 14'($urandom);
    end else begin
      rad = $urandom_range(a + b + 50, (a > b ? a - b : b - a));
      if (rad > 8000) rad = 8000;
      ang = $urandom_range(359);
      zz = hgt - $urandom_range(rad) + rad / 2;
      if (zz > 8191) zz = 8191;
      if (zz < -8192) zz = -8192;
      x = 14'(int'($cos(ang * 3.14159265 / 180.0) * rad * 0.8));
      y = 14'(int'($sin(ang * 3.14159265 / 180.0) * rad * 0.8));
      z = 14'(zz);
    end
    send_target(x, y, z);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.target_z = '0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_BASE_HEIGHT;
    cfg_wdata = '0;
    send_idle = 24;
    recv_idle = 57;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset link lengths
    send_target(0, 0, 0);                 // base atan2 of zero
    send_target(14'sd8191, 14'sd8191, 14'sd8191);
    send_target(-14'sd8192, -14'sd8192, -14'sd8192);
    send_target(-14'sd8192, 0, 0);
    send_target(0, -14'sd8192, 14'sd8191);
    send_target(5280, 0, 2483);           // fully stretched, cosine +1
    send_target(800, 0, 2483);            // folded, cosine -1
    send_target(3000, 2000, 1000);
    send_target(-1500, 2500, 4000);
    send_target(100, 0, 2483);            // too close, clamp low

    // equal links: folded target hits zero shared denominator
    write_links(13'd0, 13'd2000, 13'd2000);
    send_target(0, 0, 0);
    send_target(2000, 0, 0);
    send_target(4000, 0, 0);
    // unit-length links give d = 2
    write_links(13'd100, 13'd1, 13'd1);
    send_target(0, 0, 100);
    send_target(1, 1, 100);
    send_target(-14'sd8192, 14'sd8191, -14'sd8192);
    write_links(13'd8191, 13'd8191, 13'd8191);
    send_target(14'sd8191, -14'sd8192, 14'sd8191);
    send_target(0, 0, -14'sd8192);
    send_target(8000, 8000, 8191);

    write_links(13'd2483, 13'd2240, 13'd3040);
    for (int i = 0; i < 230; i++) random_target(2240, 3040, 2483);
    send_idle = 57;
    recv_idle = 24;
    write_links(13'd0, 13'd1, 13'd8191);
    for (int i = 0; i < 120; i++) random_target(1, 8191, 0);
    write_links(13'd8191, 13'd4000, 13'd4000);
    for (int i = 0; i < 120; i++) random_target(4000, 4000, 8191);
    send_idle = 0;
    recv_idle = 0;
    write_links(13'd1200, 13'd3500, 13'd900);
    for (int i = 0; i < 230; i++) random_target(3500, 900, 1200);
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (NSTG + 10) @(posedge clk);
    $display("covered %0d targets over seven link settings, %0d out of reach",
             seen, flagged);
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

endmodule
